/* src/vwbp_pkg.sv */
// Package for the variable-width bit packer.
// Holds the payload structs, the queue entry type and the shared constants.
// It has no dependencies.
package vwbp_pkg;

  // Each completed unit is one byte of the packed stream.
  localparam int UNIT_BITS   = 8;
  localparam int FIELD_BITS  = 32;
  localparam int COUNT_BITS  = 6;
  // A full field plus seven pending bits completes at most four bytes.
  localparam int MAX_BYTES   = 4;
  localparam int QUEUE_DEPTH = 2;

  localparam logic ORDER_LSB_FIRST = 1'b0;
  localparam logic ORDER_MSB_FIRST = 1'b1;

  typedef enum logic {
    KIND_WRITE = 1'b0,
    KIND_ALIGN = 1'b1
  } kind_t;

  typedef struct packed {
    kind_t                  kind;
    logic [FIELD_BITS-1:0]  field_value;
    logic [COUNT_BITS-1:0]  bit_count;
  } in_t;

  typedef struct packed {
    logic [UNIT_BITS-1:0] out_byte;
    logic                 last;
  } out_t;

  // One queued request: its completed bytes in stream order and their number.
  typedef struct packed {
    logic [2:0]                          cnt;
    logic [MAX_BYTES-1:0][UNIT_BITS-1:0] bytes;
  } entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

/* src/vwbp_front.sv */
// Front end of the bit packer: accepts requests, holds the partial byte and
// works out which bytes each request completes. Depends on vwbp_pkg.
module vwbp_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic              cfg_wdata,
  input  logic              in_valid,
  output logic              in_ready,
  input  vwbp_pkg::in_t     in_data,
  input  vwbp_pkg::q_status_t q_status,
  output logic              push,
  output vwbp_pkg::entry_t  push_entry
);

  localparam int UB  = vwbp_pkg::UNIT_BITS;
  localparam int FB  = vwbp_pkg::FIELD_BITS;
  localparam int AW  = UB * (vwbp_pkg::MAX_BYTES + 1);

  logic          bit_order_r;
  logic [UB-1:0] partial_r, partial_nxt;
  logic [2:0]    filled_r, filled_nxt;

  logic [5:0]        n_sat;
  logic [FB-1:0]     mask;
  logic [FB-1:0]     masked;
  logic [5:0]        total;
  logic [AW-1:0]     lsb_acc;
  logic [FB+AW-1:0]  msb_wide;
  logic [AW-1:0]     msb_acc;
  logic [AW-1:0]     acc;
  logic [UB-1:0]     bytes_w [vwbp_pkg::MAX_BYTES+1];
  logic [2:0]        nbytes;
  logic              accept;

  assign in_ready = !q_status.full;
  assign accept   = in_valid && in_ready;

  always_comb begin
    n_sat   = (in_data.bit_count > 6'd32) ? 6'd32 : in_data.bit_count;
    mask    = n_sat[5] ? '1 : ~({FB{1'b1}} << n_sat[4:0]);
    masked  = in_data.field_value & mask;
    total   = {3'b000, filled_r} + n_sat;
    // LSB first: new bits sit just above the pending ones.
    lsb_acc = {{(AW-UB){1'b0}}, partial_r} | ({{(AW-FB){1'b0}}, masked} << filled_r);
    // MSB first: the stream runs from the top bit down, so the field's top
    // bit lands just below the pending bits.
    msb_wide = {masked, {AW{1'b0}}} >> total;
    msb_acc  = msb_wide[AW-1:0] | {partial_r, {(AW-UB){1'b0}}};
    acc      = (bit_order_r == vwbp_pkg::ORDER_MSB_FIRST) ? msb_acc : lsb_acc;
    for (int k = 0; k <= vwbp_pkg::MAX_BYTES; k++) begin
      if (bit_order_r == vwbp_pkg::ORDER_MSB_FIRST) begin
        bytes_w[k] = acc[UB*(vwbp_pkg::MAX_BYTES-k) +: UB];
      end else begin
        bytes_w[k] = acc[UB*k +: UB];
      end
    end
  end

  always_comb begin
    push_entry = '0;
    if (in_data.kind == vwbp_pkg::KIND_ALIGN) begin
      nbytes              = (filled_r != 3'd0) ? 3'd1 : 3'd0;
      push_entry.bytes[0] = partial_r;
      partial_nxt         = '0;
      filled_nxt          = 3'd0;
    end else begin
      nbytes      = total[5:3];
      partial_nxt = bytes_w[nbytes];
      filled_nxt  = total[2:0];
      for (int k = 0; k < vwbp_pkg::MAX_BYTES; k++) begin
        push_entry.bytes[k] = bytes_w[k];
      end
    end
    push_entry.cnt = nbytes;
    push           = accept && (nbytes != 3'd0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bit_order_r <= vwbp_pkg::ORDER_LSB_FIRST;
      partial_r   <= '0;
      filled_r    <= 3'd0;
    end else begin
      if (cfg_we) begin
        bit_order_r <= cfg_wdata;
      end
      if (accept) begin
        partial_r <= partial_nxt;
        filled_r  <= filled_nxt;
      end
    end
  end

endmodule

/* src/vwbp_queue.sv */
// Short queue of completed-byte groups between the packer front and back.
// Register based, power-of-two depth. Depends on vwbp_pkg.
module vwbp_queue #(
  parameter int DEPTH = vwbp_pkg::QUEUE_DEPTH
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  vwbp_pkg::entry_t    push_entry,
  input  logic                pop,
  output vwbp_pkg::entry_t    head,
  output vwbp_pkg::q_status_t status
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  vwbp_pkg::entry_t mem_r [DEPTH];
  logic [PW-1:0]    wr_ptr_r, rd_ptr_r;
  logic [CW-1:0]    count_r;

  assign status.full  = (count_r == CW'(DEPTH));
  assign status.empty = (count_r == '0);
  assign head         = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

/* src/vwbp_back.sv */
// Back end of the bit packer: takes byte groups from the queue, sends them out
// via an output register, one byte per cycle unless stalled. Uses vwbp_pkg.
module vwbp_back (
  input  logic                clk,
  input  logic                rst_n,
  input  vwbp_pkg::entry_t    head,
  input  vwbp_pkg::q_status_t q_status,
  output logic                pop,
  output logic                out_valid,
  input  logic                out_ready,
  output vwbp_pkg::out_t      out_data
);

  logic             ent_valid_r;
  vwbp_pkg::entry_t ent_r;
  logic [1:0]       idx_r;
  logic             out_valid_r;
  vwbp_pkg::out_t   out_data_r;

  logic adv;
  logic is_last;
  logic done;

  always_comb begin
    adv     = ent_valid_r && (!out_valid_r || out_ready);
    is_last = ({1'b0, idx_r} == (ent_r.cnt - 3'd1));
    done    = adv && is_last;
    pop     = !q_status.empty && (!ent_valid_r || done);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_data_r.out_byte <= ent_r.bytes[idx_r];
      out_data_r.last     <= is_last;
    end
    if (pop) begin
      ent_r <= head;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ent_valid_r <= 1'b0;
      idx_r       <= 2'd0;
      out_valid_r <= 1'b0;
    end else begin
      if (adv) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (pop) begin
        ent_valid_r <= 1'b1;
        idx_r       <= 2'd0;
      end else if (done) begin
        ent_valid_r <= 1'b0;
      end else if (adv) begin
        idx_r <= idx_r + 2'd1;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

/* src/variable_width_bit_packer_top.sv */
// Top level of the variable-width bit packer.
// Instantiates vwbp_front, vwbp_queue and vwbp_back; types from vwbp_pkg.
//
//   Channel  Direction  Handshake            Payload
//   in_      input      in_valid / in_ready  vwbp_pkg::in_t (kind, field_value, bit_count)
//   out_     output     out_valid/out_ready  vwbp_pkg::out_t (out_byte, last)
//   cfg_     input      cfg_we               cfg_wdata (bit_order)
//
// A request is taken in every cycle while the queue has room; the front end
// resolves it in that cycle. The output side sends one byte per cycle while
// out_ready is high, so the one to four bytes that a request completes leave
// back to back, and sustained throughput is the output register's one byte
// per cycle. A request's first byte passes through the queue, the back end's
// entry register and the output register. Reset is synchronous and active
// low; it clears the pending bits, the queue and the output register, and
// selects least significant bit first. A stalled output only holds up the
// input once the queue and the byte in service are both occupied.
module variable_width_bit_packer_top #(
  parameter int QUEUE_DEPTH = vwbp_pkg::QUEUE_DEPTH
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           cfg_we,
  input  logic           cfg_wdata,
  input  logic           in_valid,
  output logic           in_ready,
  input  vwbp_pkg::in_t  in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output vwbp_pkg::out_t out_data
);

  // Front to queue: the bytes that one request completes.
  logic                push;
  vwbp_pkg::entry_t    push_entry;
  // Queue to back: the oldest group and the fill status.
  logic                pop;
  vwbp_pkg::entry_t    head;
  vwbp_pkg::q_status_t q_status;

  vwbp_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .q_status   (q_status),
    .push       (push),
    .push_entry (push_entry)
  );

  vwbp_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head       (head),
    .status     (q_status)
  );

  vwbp_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (head),
    .q_status  (q_status),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

/* src/vwbp_checker.sv */
// Port-level checks for the variable-width bit packer, bound to the top level.
// Depends on vwbp_pkg for the output payload type.
module vwbp_checker (
  input logic           clk,
  input logic           rst_n,
  input logic           in_ready,
  input logic           out_valid,
  input logic           out_ready,
  input vwbp_pkg::out_t out_data
);

  // A byte that is not taken stays on the port unchanged.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("output byte changed while stalled");

  // Leaving reset, nothing is offered and the input side is open.
  a_reset_state: assert property (@(posedge clk)
    !rst_n |=> !out_valid && (!rst_n || in_ready))
    else $error("bad state after reset");

  // The bytes of one request follow each other without a gap.
  a_group_contiguous: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_data.last |=> out_valid)
    else $error("gap inside a byte group");

endmodule

bind variable_width_bit_packer_top vwbp_checker u_vwbp_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
